>>> rtl/afd_pkg.sv
// Package: shared types and constants for the ADTS frame delimiter.
`timescale 1ns / 1ps
package afd_pkg;

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_HDR2    = 4'd2,
		PH_HDR3    = 4'd3,
		PH_HDR4    = 4'd4,
		PH_HDR5    = 4'd5,
		PH_HDR6    = 4'd6,
		PH_CRC1    = 4'd7,
		PH_CRC2    = 4'd8,
		PH_PAYLOAD = 4'd9
	} afd_phase_t;

	localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
	localparam logic [7:0]  ID_MASK       = 8'hF0;
	localparam logic [7:0]  LAYER_MASK    = 8'h06;
	localparam logic [7:0]  PROT_MASK     = 8'h01;
	localparam logic [13:0] HDR_BYTES     = 14'd7;
	localparam logic [13:0] CRC_BYTES     = 14'd2;
	localparam logic [12:0] LEN_SHORT_NC  = 13'd8;
	localparam logic [12:0] LEN_SHORT_CRC = 13'd10;

	typedef struct packed {
		logic [12:0] frame_length;
		logic        crc_absent;
		logic        short_frame;
	} afd_result_t;

endpackage

>>> rtl/adts_frame_delimiter_top.sv
// Top level of the ADTS frame delimiter: byte parser and result buffer.
// A frame result is registered from its last payload byte (skid entry under stall).
// Throughput: one byte per cycle; input stalls only when the result register and its
//   skid entry both hold results not yet taken.
// Reset: arst_n low clears the parse phase, counters and both result valid flags at once;
//   the block starts in sync search.
`timescale 1ns / 1ps
module adts_frame_delimiter_top import afd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	// frame results
	output logic        out_valid,
	input  logic        out_ready,
	output logic [12:0] frame_length,
	output logic        crc_absent,
	output logic        short_frame
);

	logic        accept;
	logic        res_valid;
	logic        space;
	afd_result_t res;
	afd_result_t out_res;

	// a byte transfers whenever the skid entry is free
	assign in_ready = space;
	assign accept   = in_valid && in_ready;

	// phase machine and length bookkeeping, one byte per cycle while in_ready is high
	afd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register plus skid entry
	afd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign frame_length = out_res.frame_length;
	assign crc_absent   = out_res.crc_absent;
	assign short_frame  = out_res.short_frame;

	// a result only comes from a byte that actually transferred
	a_res_from_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> accept)
		else $error("result without input transfer");

	// skid is only filled behind a full result register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

	// a short frame is header, optional CRC and one payload byte
	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && short_frame) |->
			((crc_absent && frame_length == LEN_SHORT_NC) ||
			 (!crc_absent && frame_length == LEN_SHORT_CRC)))
		else $error("short frame with unexpected length");

endmodule

>>> rtl/afd_parser.sv
// Header parser: phase register, length and byte counters, result detection.
`timescale 1ns / 1ps
module afd_parser import afd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	output logic        res_valid,
	output afd_result_t res
);

	afd_phase_t  phase_q, phase_d;
	logic [13:0] payload_left_q, payload_left_d;
	logic [12:0] bytes_q, bytes_d;
	logic        no_crc_q, no_crc_d;

	logic        bad_id;
	logic        left_le1;
	logic        left_le0;
	logic [12:0] bytes_inc;
	logic [13:0] hdr_len;
	logic [13:0] frame_len;

	assign bad_id    = ((data_byte & ID_MASK) != ID_MASK) || ((data_byte & LAYER_MASK) != 8'd0);
	assign left_le0  = payload_left_q[13] || (payload_left_q == 14'd0);
	assign left_le1  = left_le0 || (payload_left_q == 14'd1);
	assign bytes_inc = bytes_q + 13'd1;
	assign hdr_len   = no_crc_q ? HDR_BYTES : HDR_BYTES + CRC_BYTES;
	assign frame_len = {1'b0, payload_left_q[12:3], data_byte[7:5]};

	// next phase
	always_comb begin
		case (phase_q)
			PH_SYNC1:   phase_d = (data_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
			PH_SYNC2:   phase_d = bad_id ? PH_SYNC1 : PH_HDR2;
			PH_HDR2:    phase_d = PH_HDR3;
			PH_HDR3:    phase_d = PH_HDR4;
			PH_HDR4:    phase_d = PH_HDR5;
			PH_HDR5:    phase_d = PH_HDR6;
			PH_HDR6:    phase_d = no_crc_q ? PH_PAYLOAD : PH_CRC1;
			PH_CRC1:    phase_d = PH_CRC2;
			PH_CRC2:    phase_d = PH_PAYLOAD;
			PH_PAYLOAD: phase_d = left_le1 ? PH_SYNC1 : PH_PAYLOAD;
			default:    phase_d = PH_SYNC1;
		endcase
	end

	// counters, flag and result
	always_comb begin
		payload_left_d = payload_left_q;
		bytes_d        = bytes_inc;
		no_crc_d       = no_crc_q;
		res_valid      = 1'b0;
		res            = '{frame_length: bytes_inc, crc_absent: no_crc_q,
			short_frame: left_le0};
		case (phase_q)
			PH_SYNC1: begin
				payload_left_d = '0;
				no_crc_d       = 1'b0;
				bytes_d        = (data_byte == SYNC_BYTE) ? 13'd1 : 13'd0;
			end
			PH_SYNC2: begin
				if (bad_id) begin
					payload_left_d = '0;
					bytes_d        = '0;
					no_crc_d       = 1'b0;
				end else begin
					no_crc_d = |(data_byte & PROT_MASK);
				end
			end
			PH_HDR3: payload_left_d = {1'b0, data_byte[1:0], 11'd0};
			PH_HDR4: payload_left_d = payload_left_q | {3'd0, data_byte, 3'd0};
			PH_HDR5: payload_left_d = frame_len - hdr_len;
			PH_PAYLOAD: begin
				if (left_le1) begin
					res_valid      = accept;
					payload_left_d = '0;
					bytes_d        = '0;
					no_crc_d       = 1'b0;
				end else begin
					payload_left_d = payload_left_q - 14'd1;
				end
			end
			PH_HDR2, PH_HDR6, PH_CRC1, PH_CRC2: ;
			default: begin
				payload_left_d = '0;
				bytes_d        = '0;
				no_crc_d       = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SYNC1;
			payload_left_q <= '0;
			bytes_q        <= '0;
			no_crc_q       <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			payload_left_q <= payload_left_d;
			bytes_q        <= bytes_d;
			no_crc_q       <= no_crc_d;
		end
	end

endmodule

>>> rtl/afd_out_buf.sv
// Result register with a skid entry so input keeps flowing under output stall until the skid fills.
`timescale 1ns / 1ps
module afd_out_buf import afd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  afd_result_t res,
	output logic        space,
	output logic        out_valid,
	input  logic        out_ready,
	output afd_result_t out_res
);

	logic        main_valid_q;
	logic        skid_valid_q;
	afd_result_t main_q;
	afd_result_t skid_q;
	logic        main_hold;

	assign main_hold = main_valid_q && !out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_hold) begin
			if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			main_valid_q <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			main_valid_q <= res_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (main_hold) begin
			if (res_valid) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			main_q <= skid_q;
		end else if (res_valid) begin
			main_q <= res;
		end
	end

endmodule
